// File: rtl/bbc_pkg.sv
// Package for the bracket balance checker.
// Holds kind codes, character decode functions and the stage-to-stage struct.
// No dependencies.
`default_nettype none

package bbc_pkg;

   localparam int DEPTH_DEFAULT = 64;

   typedef enum logic [1:0] {
      KIND_ROUND  = 2'd0,
      KIND_SQUARE = 2'd1,
      KIND_CURLY  = 2'd2,
      KIND_OTHER  = 2'd3
   } kind_type;

   localparam logic [7:0] CHAR_ROUND_OPEN   = 8'h28;
   localparam logic [7:0] CHAR_ROUND_CLOSE  = 8'h29;
   localparam logic [7:0] CHAR_SQUARE_OPEN  = 8'h5B;
   localparam logic [7:0] CHAR_SQUARE_CLOSE = 8'h5D;
   localparam logic [7:0] CHAR_CURLY_OPEN   = 8'h7B;
   localparam logic [7:0] CHAR_CURLY_CLOSE  = 8'h7D;

   // Item handed from the stack front end to the match check stage.
   typedef struct packed {
      logic     valid;
      logic     pop;
      logic     empty_err;
      kind_type closer;
      logic     last;
      logic     depth_zero;
      logic     ovf;
   } stage_type;

   function automatic kind_type opener_kind(input logic [7:0] ch);
      kind_type k;
      unique case (ch)
         CHAR_ROUND_OPEN:  k = KIND_ROUND;
         CHAR_SQUARE_OPEN: k = KIND_SQUARE;
         CHAR_CURLY_OPEN:  k = KIND_CURLY;
         default:          k = KIND_OTHER;
      endcase
      return k;
   endfunction

   function automatic kind_type closer_kind(input logic [7:0] ch);
      kind_type k;
      unique case (ch)
         CHAR_ROUND_CLOSE:  k = KIND_ROUND;
         CHAR_SQUARE_CLOSE: k = KIND_SQUARE;
         CHAR_CURLY_CLOSE:  k = KIND_CURLY;
         default:           k = KIND_OTHER;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// File: rtl/bbc_if.sv
// Valid/ready channel interfaces for the bracket balance checker.
// Depends on nothing.
`default_nettype none

interface bbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       last;

   modport source (output valid, output char_in, output last, input ready);
   modport sink (input valid, input char_in, input last, output ready);
endinterface

interface bbc_rsp_if;
   logic valid;
   logic ready;
   logic valid_res;
   logic overflow;

   modport source (output valid, output valid_res, output overflow, input ready);
   modport sink (input valid, input valid_res, input overflow, output ready);
endinterface

`default_nettype wire

// File: rtl/bbc_stack_ram.sv
// Kind stack storage: one write port, one registered read port.
// Depends on bbc_pkg.
`default_nettype none

module bbc_stack_ram #(
   parameter int DEPTH = bbc_pkg::DEPTH_DEFAULT,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  var  bbc_pkg::kind_type wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output bbc_pkg::kind_type      rd_data
);

   bbc_pkg::kind_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/bbc_front.sv
// Stack front end: decodes each item, moves the depth count, tracks overflow
// and drives the stack memory. Depends on bbc_pkg, bbc_if.
`default_nettype none

module bbc_front #(
   parameter int DEPTH = bbc_pkg::DEPTH_DEFAULT,
   localparam int AW = $clog2(DEPTH),
   localparam int DW = $clog2(DEPTH + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   bbc_req_if.sink            req_chan,
   input  wire logic          advance,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output bbc_pkg::kind_type  wr_data,
   output logic               rd_en,
   output logic [AW-1:0]      rd_addr,
   output bbc_pkg::stage_type stage
);

   logic [DW-1:0]      depth_ff, depth_in;
   logic               ovf_ff, ovf_in;
   bbc_pkg::stage_type stage_ff, stage_in;

   logic              accept;
   logic              is_close;
   logic              empty;
   logic              full;
   bbc_pkg::kind_type ck;
   logic [DW-1:0]     depth_step;
   logic              ovf_step;

   assign req_chan.ready = advance;
   assign accept = req_chan.valid & advance;

   assign ck       = bbc_pkg::closer_kind(req_chan.char_in);
   assign is_close = (ck != bbc_pkg::KIND_OTHER);
   assign empty    = (depth_ff == '0);
   assign full     = (depth_ff == DW'(DEPTH));

   always_comb begin
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      wr_addr    = depth_ff[AW-1:0];
      rd_addr    = AW'(depth_ff - DW'(1));
      wr_data    = bbc_pkg::opener_kind(req_chan.char_in);
      depth_step = depth_ff;
      ovf_step   = ovf_ff;
      if (is_close) begin
         if (!empty) begin
            rd_en      = accept;
            depth_step = depth_ff - DW'(1);
         end
      end else begin
         if (full) begin
            ovf_step = 1'b1;
         end else begin
            wr_en      = accept;
            depth_step = depth_ff + DW'(1);
         end
      end
   end

   always_comb begin
      depth_in = depth_ff;
      ovf_in   = ovf_ff;
      stage_in = stage_ff;
      if (advance) begin
         stage_in.valid = 1'b0;
      end
      if (accept) begin
         depth_in            = req_chan.last ? '0 : depth_step;
         ovf_in              = req_chan.last ? 1'b0 : ovf_step;
         stage_in.valid      = 1'b1;
         stage_in.pop        = is_close & ~empty;
         stage_in.empty_err  = is_close & empty;
         stage_in.closer     = ck;
         stage_in.last       = req_chan.last;
         stage_in.depth_zero = (depth_step == '0);
         stage_in.ovf        = ovf_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff       <= '0;
         ovf_ff         <= 1'b0;
         stage_ff       <= '0;
      end else begin
         depth_ff       <= depth_in;
         ovf_ff         <= ovf_in;
         stage_ff       <= stage_in;
      end
   end

   assign stage = stage_ff;

endmodule

`default_nettype wire

// File: rtl/bbc_check.sv
// Match check stage: compares the popped kind, keeps the sticky mismatch
// flag and holds the result register. Depends on bbc_pkg, bbc_if.
`default_nettype none

module bbc_check (
   input  wire logic              clock,
   input  wire logic              reset,
   input  var  bbc_pkg::stage_type stage,
   input  var  bbc_pkg::kind_type  rd_data,
   output logic                   advance,
   bbc_rsp_if.source              rsp_chan
);

   logic mismatch_ff, mismatch_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic valid_res_ff, valid_res_in;
   logic overflow_ff, overflow_in;

   logic kind_bad;
   logic mis_total;
   logic emit;

   assign kind_bad  = stage.pop && (rd_data != bbc_pkg::KIND_OTHER) && (rd_data != stage.closer);
   assign mis_total = mismatch_ff | stage.empty_err | kind_bad;

   assign advance = ~stage.valid | ~stage.last | ~rsp_valid_ff | rsp_chan.ready;
   assign emit    = stage.valid & stage.last & advance;

   always_comb begin
      mismatch_in  = mismatch_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      valid_res_in = valid_res_ff;
      overflow_in  = overflow_ff;
      if (stage.valid && advance) begin
         mismatch_in = stage.last ? 1'b0 : mis_total;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         valid_res_in = stage.depth_zero & ~mis_total & ~stage.ovf;
         overflow_in  = stage.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mismatch_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mismatch_ff  <= mismatch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      valid_res_ff <= valid_res_in;
      overflow_ff  <= overflow_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.valid_res = valid_res_ff;
   assign rsp_chan.overflow  = overflow_ff;

endmodule

`default_nettype wire

// File: rtl/bracket_balance_checker_core.sv
// Bracket balance checker top level. A last item's result is registered
// in the stage register and then in the result register. One item per
// cycle; the stack memory read port is registered beside the stage
// register and input stalls only while a last item waits for a full
// result register. Reset clears only depth, sticky flags and valid bits.
`default_nettype none

module bracket_balance_checker_core #(
   parameter int DEPTH = bbc_pkg::DEPTH_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   bbc_req_if.sink   req_chan,
   bbc_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(DEPTH);

   logic               advance;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   bbc_pkg::kind_type  wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   bbc_pkg::kind_type  rd_data;
   bbc_pkg::stage_type stage;

   bbc_front #(.DEPTH(DEPTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .stage    (stage)
   );

   bbc_stack_ram #(.DEPTH(DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bbc_check u_check (
      .clock    (clock),
      .reset    (reset),
      .stage    (stage),
      .rd_data  (rd_data),
      .advance  (advance),
      .rsp_chan (rsp_chan)
   );

   a_stall_only_on_last: assert property (@(posedge clock) disable iff (reset)
      !advance |-> (stage.valid && stage.last))
      else $error("stall without a pending last item");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(stage))
      else $error("stalled item changed");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (stage.valid && stage.last && advance) |=> rsp_chan.valid)
      else $error("last item produced no result");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      stage.valid |-> !(stage.pop && stage.empty_err))
      else $error("pop flagged on empty stack");

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Testbench for bracket_balance_checker_core: drives byte strings through the
// request channel and checks each verdict against an in-bench stack model.
// Depends on bbc_pkg, bbc_if and the core RTL.
`timescale 1ns / 1ps

module testbench;
   import bbc_pkg::*;

   localparam int DEPTH       = DEPTH_DEFAULT;
   localparam int AW          = $clog2(DEPTH);
   localparam int ITEM_TARGET = 1150;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 200;
   localparam logic [7:0] BRACKET_CHARS [6] = '{
      CHAR_ROUND_OPEN, CHAR_ROUND_CLOSE, CHAR_SQUARE_OPEN,
      CHAR_SQUARE_CLOSE, CHAR_CURLY_OPEN, CHAR_CURLY_CLOSE
   };

   typedef struct packed {
      logic valid_res;
      logic overflow;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bbc_req_if req_chan ();
   bbc_rsp_if rsp_chan ();

   bracket_balance_checker_core #(.DEPTH(DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   kind_type    open_kinds [DEPTH];
   int unsigned open_count    = 0;
   logic        mismatch_flag = 1'b0;
   logic        overflow_flag = 1'b0;
   verdict_type expected_verdicts [$];

   logic [7:0]  text_buf [$];
   logic [7:0]  pending_closers [$];

   int items_sent  = 0;
   int fail_count  = 0;
   int cycle_count = 0;
   int hold_left   = 0;
   int stall_left  = 0;
   bit send_idle   = 1'b1;
   bit recv_idle   = 1'b1;

   // Stack model: update on one accepted character, queue a verdict on last.
   function automatic void predict_char(input logic [7:0] ch, input logic lst);
      kind_type    want;
      kind_type    push_kind;
      logic        is_close;
      verdict_type v;
      is_close = 1'b1;
      want = KIND_OTHER;
      case (ch)
         CHAR_ROUND_CLOSE:  want = KIND_ROUND;
         CHAR_SQUARE_CLOSE: want = KIND_SQUARE;
         CHAR_CURLY_CLOSE:  want = KIND_CURLY;
         default:           is_close = 1'b0;
      endcase
      case (ch)
         CHAR_ROUND_OPEN:  push_kind = KIND_ROUND;
         CHAR_SQUARE_OPEN: push_kind = KIND_SQUARE;
         CHAR_CURLY_OPEN:  push_kind = KIND_CURLY;
         default:          push_kind = KIND_OTHER;
      endcase
      if (is_close) begin
         if (open_count == 0) begin
            mismatch_flag = 1'b1;
         end else begin
            open_count--;
            if (open_kinds[AW'(open_count)] != KIND_OTHER &&
                open_kinds[AW'(open_count)] != want)
               mismatch_flag = 1'b1;
         end
      end else if (open_count >= DEPTH) begin
         overflow_flag = 1'b1;
      end else begin
         open_kinds[AW'(open_count)] = push_kind;
         open_count++;
      end
      if (lst) begin
         v.valid_res = (open_count == 0) && !mismatch_flag && !overflow_flag;
         v.overflow  = overflow_flag;
         expected_verdicts.insert(expected_verdicts.size(), v);
         open_count    = 0;
         mismatch_flag = 1'b0;
         overflow_flag = 1'b0;
      end
   endfunction

   function automatic int pick_gap(input bit on);
      int r;
      r = $urandom_range(0, 99);
      if (!on || r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] filler_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == CHAR_ROUND_CLOSE || b == CHAR_SQUARE_CLOSE || b == CHAR_CURLY_CLOSE);
      return b;
   endfunction

   function automatic logic [7:0] bracket_or_byte();
      if ($urandom_range(0, 1) == 1)
         return BRACKET_CHARS[3'($urandom_range(0, 5))];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void append_text(input logic [7:0] ch);
      text_buf.insert(text_buf.size(), ch);
   endfunction

   function automatic void stack_closer(input logic [7:0] ch);
      pending_closers.insert(pending_closers.size(), ch);
   endfunction

   function automatic logic [7:0] take_closer();
      logic [7:0] c;
      c = pending_closers[$];
      pending_closers.delete(pending_closers.size() - 1);
      return c;
   endfunction

   // Push an opener or filler byte and remember a closer (random for a filler).
   function automatic void open_one();
      case ($urandom_range(0, 3))
         0: begin
            append_text(CHAR_ROUND_OPEN);
            stack_closer(CHAR_ROUND_CLOSE);
         end
         1: begin
            append_text(CHAR_SQUARE_OPEN);
            stack_closer(CHAR_SQUARE_CLOSE);
         end
         2: begin
            append_text(CHAR_CURLY_OPEN);
            stack_closer(CHAR_CURLY_CLOSE);
         end
         default: begin
            append_text(filler_byte());
            stack_closer(BRACKET_CHARS[3'(2 * $urandom_range(0, 2) + 1)]);
         end
      endcase
   endfunction

   function automatic void build_balanced(input int pairs);
      int opened;
      opened = 0;
      text_buf.delete();
      pending_closers.delete();
      while (opened < pairs || pending_closers.size() != 0) begin
         if (opened < pairs && (pending_closers.size() == 0 || $urandom_range(0, 1) == 1)) begin
            open_one();
            opened++;
         end else begin
            append_text(take_closer());
         end
      end
   endfunction

   function automatic void build_deep(input int levels);
      text_buf.delete();
      pending_closers.delete();
      repeat (levels) open_one();
      while (pending_closers.size() != 0)
         append_text(take_closer());
   endfunction

   function automatic void build_noise(input int len);
      text_buf.delete();
      repeat (len) append_text(bracket_or_byte());
   endfunction

   task automatic send_char(input logic [7:0] ch, input logic lst);
      int gap;
      req_chan.valid   = 1'b1;
      req_chan.char_in = ch;
      req_chan.last    = lst;
      do
         @(posedge clock);
      while (req_chan.ready !== 1'b1);
      predict_char(ch, lst);
      items_sent++;
      @(negedge clock);
      gap = pick_gap(send_idle);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_text();
      foreach (text_buf[i])
         send_char(text_buf[i], i == text_buf.size() - 1);
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], i == s.len() - 1);
   endtask

   task automatic wait_drained();
      req_chan.valid = 1'b0;
      while (expected_verdicts.size() != 0)
         @(negedge clock);
   endtask

   task automatic test_single_bytes();
      logic [7:0] singles [9];
      singles = '{CHAR_ROUND_OPEN, CHAR_ROUND_CLOSE, CHAR_SQUARE_OPEN, CHAR_SQUARE_CLOSE,
                  CHAR_CURLY_OPEN, CHAR_CURLY_CLOSE, 8'h61, 8'h00, 8'hFF};
      foreach (singles[i])
         send_char(singles[i], 1'b1);
   endtask

   task automatic test_nesting();
      send_string("()");
      send_string("[}");
      send_string("a]");
      send_string("((");
      send_string("}{");
      send_string("([{}])");
      wait_drained();
   endtask

   task automatic test_overflow();
      repeat (DEPTH) send_char(CHAR_ROUND_OPEN, 1'b0);
      for (int i = 0; i < DEPTH; i++)
         send_char(CHAR_ROUND_CLOSE, i == DEPTH - 1);
      repeat (DEPTH) send_char(CHAR_CURLY_OPEN, 1'b0);
      send_char(8'h78, 1'b0);
      for (int i = 0; i < DEPTH; i++)
         send_char(CHAR_CURLY_CLOSE, i == DEPTH - 1);
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_idle = 1'b0;
      recv_idle = 1'b0;
      hold_left = LONG_HOLD;
      repeat (40) begin
         if ($urandom_range(0, 3) == 0)
            send_char(bracket_or_byte(), 1'b0);
         send_char(bracket_or_byte(), 1'b1);
      end
      wait_drained();
      send_idle = 1'b1;
      recv_idle = 1'b1;
   endtask

   task automatic test_random_strings();
      int mode;
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 15) == 0) begin
            send_idle = $urandom_range(0, 3) != 0;
            recv_idle = $urandom_range(0, 3) != 0;
         end
         mode = $urandom_range(0, 99);
         if (mode < 60) begin
            build_balanced($urandom_range(1, 8));
         end else if (mode < 82) begin
            build_balanced($urandom_range(1, 8));
            text_buf[$urandom_range(0, text_buf.size() - 1)] = bracket_or_byte();
         end else if (mode < 96) begin
            build_noise($urandom_range(1, 12));
         end else begin
            build_deep($urandom_range(DEPTH - 3, DEPTH + 3));
         end
         send_text();
      end
      wait_drained();
   endtask

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_chan.ready = 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_chan.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready = 1'b1;
            stall_left = pick_gap(recv_idle);
         end
      end
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_verdicts.size() == 0) begin
            $error("unexpected result: valid_res=%0b overflow=%0b",
                   rsp_chan.valid_res, rsp_chan.overflow);
            fail_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_chan.valid_res !== want.valid_res) begin
               $error("valid_res: expected %0b, actual %0b", want.valid_res,
                      rsp_chan.valid_res);
               fail_count++;
            end
            if (rsp_chan.overflow !== want.overflow) begin
               $error("overflow: expected %0b, actual %0b", want.overflow,
                      rsp_chan.overflow);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[bracket_balance_checker_core] ERROR");
         $finish;
      end
   end

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.char_in = 8'h00;
      req_chan.last    = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_single_bytes();
      test_nesting();
      test_overflow();
      test_backpressure();
      test_random_strings();
      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("[bracket_balance_checker_core] OK");
      else
         $display("[bracket_balance_checker_core] ERROR");
      $finish;
   end

endmodule
